// ===== rtl/core/lmfb_pkg.sv =====
// shared constants and command codes of the led matrix frame buffer
`default_nettype none

package lmfb_pkg;

  localparam int unsigned DefDisplays = 4;
  localparam int unsigned Rows        = 8;

  localparam int unsigned KindW = 3;
  localparam int unsigned DispW = 2;
  localparam int unsigned RowW  = 3;
  localparam int unsigned ByteW = 8;
  localparam int unsigned PatW  = 64;

  localparam logic [KindW-1:0] KIND_CLEAR    = 3'd0;
  localparam logic [KindW-1:0] KIND_SET_ROW  = 3'd1;
  localparam logic [KindW-1:0] KIND_LOAD     = 3'd2;
  localparam logic [KindW-1:0] KIND_ROT_UP   = 3'd3;
  localparam logic [KindW-1:0] KIND_ROT_DOWN = 3'd4;
  localparam logic [KindW-1:0] KIND_REFRESH  = 3'd5;

  localparam logic [RowW-1:0] LAST_ROW = 3'd7;

endpackage

`default_nettype wire

// ===== rtl/core/lmfb_ram.sv =====
// generic simple dual-port ram, one write port, one registered read port
`default_nettype none

module lmfb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/led_matrix_frame_buffer_unit.sv =====
// top level of the led matrix frame buffer: command sequencer around the row store
//
// Frame store of 8 row bytes for each of DISPLAYS chained 8x8 matrices, all zero after
// reset; each input word is one command. Clear and set row complete in the accept cycle.
// Load pattern writes one row per cycle after the accept cycle. A rotate fetches the
// carry bit of each row, then reads each display's entry and writes it back shifted in
// the next cycle. A refresh reads each row into the output register, holding while the
// output stalls. Both use the single row memory. Unused command codes are dropped. A
// new command is taken while the last refresh row still waits at the output.
`default_nettype none

module led_matrix_frame_buffer_unit #(
  parameter int unsigned DISPLAYS = lmfb_pkg::DefDisplays
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [lmfb_pkg::KindW-1:0] kind_i,
  input  wire logic [lmfb_pkg::DispW-1:0] display_index_i,
  input  wire logic [lmfb_pkg::RowW-1:0]  row_index_i,
  input  wire logic [lmfb_pkg::ByteW-1:0] row_byte_i,
  input  wire logic [lmfb_pkg::PatW-1:0]  pattern_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic      [lmfb_pkg::DispW-1:0] out_display_o,
  output logic      [lmfb_pkg::RowW-1:0]  out_row_o,
  output logic      [lmfb_pkg::ByteW-1:0] out_bits_o,
  output logic                            last_o
);

  import lmfb_pkg::*;

  localparam int unsigned Depth = DISPLAYS * Rows;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned DW    = (DISPLAYS > 1) ? $clog2(DISPLAYS) : 1;
  localparam logic [DW-1:0] LastDisp = DW'(DISPLAYS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_RCAR = 3'd2;
  localparam logic [2:0] S_RCAP = 3'd3;
  localparam logic [2:0] S_RRD  = 3'd4;
  localparam logic [2:0] S_RWR  = 3'd5;
  localparam logic [2:0] S_FRD  = 3'd6;
  localparam logic [2:0] S_FWR  = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [DW-1:0]    disp_q, disp_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [PatW-1:0]  pat_q, pat_d;
  logic             up_q, up_d;
  logic             carry_q, carry_d;
  logic [Depth-1:0] vld_q, vld_d;
  logic             rd_vld_q, rd_vld_d;

  logic             out_vld_q, out_vld_d;
  logic [DispW-1:0] out_disp_q, out_disp_d;
  logic [RowW-1:0]  out_row_q, out_row_d;
  logic [ByteW-1:0] out_bits_q, out_bits_d;
  logic             out_last_q, out_last_d;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [ByteW-1:0] ram_wdata, ram_rdata, rd;

  logic          in_acc;
  logic          disp_ok;
  logic [DW-1:0] dsel;
  logic [DW-1:0] csrc;
  logic [DW-1:0] rot_end;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign disp_ok    = int'(display_index_i) < DISPLAYS;
  assign dsel       = DW'(display_index_i);
  assign csrc       = up_q ? LastDisp : '0;
  assign rot_end    = up_q ? LastDisp : '0;

  // entries never written since reset or clear read as zero
  assign rd = rd_vld_q ? ram_rdata : '0;

  always_comb begin
    state_d    = state_q;
    disp_d     = disp_q;
    row_d      = row_q;
    pat_d      = pat_q;
    up_d       = up_q;
    carry_d    = carry_q;
    vld_d      = vld_q;
    rd_vld_d   = rd_vld_q;
    out_vld_d  = out_vld_q && out_stall_i;
    out_disp_d = out_disp_q;
    out_row_d  = out_row_q;
    out_bits_d = out_bits_q;
    out_last_d = out_last_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (kind_i) inside
            KIND_CLEAR: begin
              if (disp_ok) begin
                for (int r = 0; r < Rows; r++) begin
                  vld_d[AW'({dsel, RowW'(r)})] = 1'b0;
                end
              end
            end
            KIND_SET_ROW: begin
              if (disp_ok) begin
                ram_we    = 1'b1;
                ram_waddr = AW'({dsel, row_index_i});
                ram_wdata = row_byte_i;
                vld_d[AW'({dsel, row_index_i})] = 1'b1;
              end
            end
            KIND_LOAD: begin
              if (disp_ok) begin
                pat_d   = pattern_i;
                disp_d  = dsel;
                row_d   = '0;
                state_d = S_LOAD;
              end
            end
            KIND_ROT_UP, KIND_ROT_DOWN: begin
              up_d    = (kind_i == KIND_ROT_UP);
              row_d   = '0;
              state_d = S_RCAR;
            end
            KIND_REFRESH: begin
              disp_d  = '0;
              row_d   = '0;
              state_d = S_FRD;
            end
            default: begin
            end
          endcase
        end
      end
      S_LOAD: begin
        // low byte of the glyph goes to the bottom row
        ram_we    = 1'b1;
        ram_waddr = AW'({disp_q, ~row_q});
        ram_wdata = pat_q[ByteW-1:0];
        vld_d[AW'({disp_q, ~row_q})] = 1'b1;
        pat_d     = pat_q >> ByteW;
        row_d     = row_q + RowW'(1);
        if (row_q == LAST_ROW) begin
          state_d = S_IDLE;
        end
      end
      S_RCAR: begin
        // fetch the bit that wraps around the row word
        ram_re    = 1'b1;
        ram_raddr = AW'({csrc, row_q});
        rd_vld_d  = vld_q[AW'({csrc, row_q})];
        state_d   = S_RCAP;
      end
      S_RCAP: begin
        carry_d = up_q ? rd[ByteW-1] : rd[0];
        disp_d  = up_q ? '0 : LastDisp;
        state_d = S_RRD;
      end
      S_RRD: begin
        ram_re    = 1'b1;
        ram_raddr = AW'({disp_q, row_q});
        rd_vld_d  = vld_q[AW'({disp_q, row_q})];
        state_d   = S_RWR;
      end
      S_RWR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'({disp_q, row_q});
        ram_wdata = up_q ? {rd[ByteW-2:0], carry_q} : {carry_q, rd[ByteW-1:1]};
        vld_d[AW'({disp_q, row_q})] = 1'b1;
        carry_d   = up_q ? rd[ByteW-1] : rd[0];
        if (disp_q == rot_end) begin
          if (row_q == LAST_ROW) begin
            state_d = S_IDLE;
          end else begin
            row_d   = row_q + RowW'(1);
            state_d = S_RCAR;
          end
        end else begin
          disp_d  = up_q ? disp_q + DW'(1) : disp_q - DW'(1);
          state_d = S_RRD;
        end
      end
      S_FRD: begin
        // the output register is free by the time the read data lands
        if (!out_vld_q || !out_stall_i) begin
          ram_re    = 1'b1;
          ram_raddr = AW'({disp_q, row_q});
          rd_vld_d  = vld_q[AW'({disp_q, row_q})];
          state_d   = S_FWR;
        end
      end
      S_FWR: begin
        out_vld_d  = 1'b1;
        out_disp_d = DispW'(disp_q);
        out_row_d  = row_q;
        out_bits_d = rd;
        out_last_d = (disp_q == LastDisp) && (row_q == LAST_ROW);
        row_d      = row_q + RowW'(1);
        if (row_q == LAST_ROW) begin
          disp_d = disp_q + DW'(1);
        end
        if ((disp_q == LastDisp) && (row_q == LAST_ROW)) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_FRD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      disp_q    <= '0;
      row_q     <= '0;
      up_q      <= 1'b0;
      carry_q   <= 1'b0;
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      disp_q    <= disp_d;
      row_q     <= row_d;
      up_q      <= up_d;
      carry_q   <= carry_d;
      vld_q     <= vld_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pat_q      <= pat_d;
    out_disp_q <= out_disp_d;
    out_row_q  <= out_row_d;
    out_bits_q <= out_bits_d;
    out_last_q <= out_last_d;
  end

  lmfb_ram #(
    .Width(ByteW),
    .Depth(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o   = out_vld_q;
  assign out_display_o = out_disp_q;
  assign out_row_o     = out_row_q;
  assign out_bits_o    = out_bits_q;
  assign last_o        = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/core/lmfb_checker.sv =====
// port-level checks of the led matrix frame buffer, bound to the top level
`default_nettype none

module lmfb_checker #(
  parameter int unsigned DISPLAYS = lmfb_pkg::DefDisplays
) (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_stall_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire logic [lmfb_pkg::DispW-1:0] out_display_o,
  input wire logic [lmfb_pkg::RowW-1:0]  out_row_o,
  input wire logic [lmfb_pkg::ByteW-1:0] out_bits_o,
  input wire logic                       last_o
);

  import lmfb_pkg::*;

  logic out_acc;
  assign out_acc = out_valid_o && !out_stall_i;

  // a stalled word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_bits_o) && $stable(out_row_o)
      && $stable(out_display_o) && $stable(last_o))
    else $error("output word changed while stalled");

  // the marked word is the bottom row of the final display
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> out_row_o == LAST_ROW
      && out_display_o == DispW'(DISPLAYS - 1))
    else $error("last marker on wrong row");

  // mid-refresh the block takes no new command
  a_busy_refresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !last_o |=> in_stall_o)
    else $error("command taken during refresh");

endmodule

bind led_matrix_frame_buffer_unit lmfb_checker #(
  .DISPLAYS(DISPLAYS)
) u_lmfb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_display_o(out_display_o),
  .out_row_o    (out_row_o),
  .out_bits_o   (out_bits_o),
  .last_o       (last_o)
);

`default_nettype wire
